### rtl/core/clcd_pkg.sv
package clcd_pkg;

    // Request opcodes
    typedef enum logic [2:0] {
        OP_COMMAND = 3'd0,
        OP_DATA    = 3'd1,
        OP_CURSOR  = 3'd2,
        OP_INIT    = 3'd3,
        OP_CLEAR   = 3'd4,
        OP_HOME    = 3'd5
    } t_opcode;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE_HIGH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE_LOW  = 2'd1;

    localparam logic [15:0] ENABLE_HIGH_RESET = 16'd40;
    localparam logic [15:0] ENABLE_LOW_RESET  = 16'd100;

    // Controller commands
    localparam logic [7:0] CMD_FUNCTION_SET = 8'h28;
    localparam logic [7:0] CMD_DISPLAY_ON   = 8'h0E;
    localparam logic [7:0] CMD_CLEAR        = 8'h01;
    localparam logic [7:0] CMD_HOME         = 8'h02;
    localparam logic [7:0] CMD_ENTRY_INC    = 8'h06;
    localparam logic [7:0] ROW1_BASE        = 8'h80;
    localparam logic [7:0] ROW2_BASE        = 8'hC0;

    localparam logic [1:0] ROW_FIRST  = 2'd1;
    localparam logic [1:0] ROW_SECOND = 2'd2;

    localparam logic [3:0] NIB_WAKE     = 4'h3;
    localparam logic [3:0] NIB_FOUR_BIT = 4'h2;

    // Delays in units
    localparam logic [15:0] POWER_UP_WAIT = 16'd40000;
    localparam logic [12:0] WAKE1_WAIT    = 13'd5000;
    localparam logic [12:0] WAKE2_WAIT    = 13'd150;
    localparam logic [12:0] CLEAR_WAIT    = 13'd2000;

    localparam int STEP_W = 4;

    typedef struct packed {
        logic [2:0] opcode;
        logic [7:0] byte_value;
        logic [1:0] row;
        logic [4:0] column;
    } t_req;

    typedef struct packed {
        logic        reg_select;
        logic [3:0]  nibble;
        logic [15:0] wait_before;
        logic [12:0] wait_after;
        logic        last;
    } t_xfer;

    // Classified request as queued between front and back
    typedef struct packed {
        logic       is_init;
        logic       reg_select;
        logic [7:0] byte_val;
        logic       long_wait;
    } t_job;

    function automatic t_xfer init_xfer(input logic [STEP_W-1:0] step);
        t_xfer x;
        x = '{reg_select: 1'b0, nibble: 4'h0, wait_before: 16'd0,
              wait_after: 13'd0, last: 1'b0};
        unique case (step)
            4'd0: begin
                x.nibble      = NIB_WAKE;
                x.wait_before = POWER_UP_WAIT;
                x.wait_after  = WAKE1_WAIT;
            end
            4'd1: begin
                x.nibble     = NIB_WAKE;
                x.wait_after = WAKE2_WAIT;
            end
            4'd2:  x.nibble = NIB_WAKE;
            4'd3:  x.nibble = NIB_FOUR_BIT;
            4'd4:  x.nibble = CMD_FUNCTION_SET[7:4];
            4'd5:  x.nibble = CMD_FUNCTION_SET[3:0];
            4'd6:  x.nibble = CMD_DISPLAY_ON[7:4];
            4'd7:  x.nibble = CMD_DISPLAY_ON[3:0];
            4'd8:  x.nibble = CMD_CLEAR[7:4];
            4'd9: begin
                x.nibble     = CMD_CLEAR[3:0];
                x.wait_after = CLEAR_WAIT;
            end
            4'd10: x.nibble = CMD_ENTRY_INC[7:4];
            default: begin
                x.nibble = CMD_ENTRY_INC[3:0];
                x.last   = 1'b1;
            end
        endcase
        return x;
    endfunction

endpackage

### rtl/core/clcd_front.sv
module clcd_front (
    input  logic           i_req_valid,
    output logic           o_req_ready,
    input  clcd_pkg::t_req i_req,
    input  logic           i_full,
    output logic           o_push,
    output clcd_pkg::t_job o_job
);
    import clcd_pkg::*;

    logic       keep;
    logic [7:0] pos;

    assign pos = {3'b000, i_req.column} + 8'hFF;

    always_comb begin
        keep  = 1'b1;
        o_job = '{is_init: 1'b0, reg_select: 1'b0, byte_val: i_req.byte_value,
                  long_wait: 1'b0};
        unique case (i_req.opcode)
            OP_COMMAND: ;
            OP_DATA:    o_job.reg_select = 1'b1;
            OP_CURSOR: begin
                if (i_req.row == ROW_FIRST) begin
                    o_job.byte_val = pos | ROW1_BASE;
                end else if (i_req.row == ROW_SECOND) begin
                    o_job.byte_val = pos | ROW2_BASE;
                end else begin
                    keep = 1'b0;
                end
            end
            OP_INIT:    o_job.is_init = 1'b1;
            OP_CLEAR: begin
                o_job.byte_val  = CMD_CLEAR;
                o_job.long_wait = 1'b1;
            end
            OP_HOME: begin
                o_job.byte_val  = CMD_HOME;
                o_job.long_wait = 1'b1;
            end
            default:    keep = 1'b0;
        endcase
    end

    // drop requests that make no transfers
    assign o_req_ready = !i_full;
    assign o_push      = i_req_valid && !i_full && keep;

endmodule

### rtl/core/clcd_fifo.sv
module clcd_fifo #(
    parameter int DEPTH = 4
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  clcd_pkg::t_job i_data,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_valid,
    output clcd_pkg::t_job o_head
);
    import clcd_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_job             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

### rtl/core/clcd_back.sv
module clcd_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_head_valid,
    input  clcd_pkg::t_job  i_head,
    output logic            o_pop,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output clcd_pkg::t_xfer o_out
);
    import clcd_pkg::*;

    logic [STEP_W-1:0] r_step;
    logic              r_out_valid;
    t_xfer             r_out;
    t_xfer             xfer;
    logic              load, fire;

    always_comb begin
        if (i_head.is_init) begin
            xfer = init_xfer(r_step);
        end else begin
            xfer.reg_select  = i_head.reg_select;
            xfer.nibble      = r_step[0] ? i_head.byte_val[3:0] : i_head.byte_val[7:4];
            xfer.wait_before = 16'd0;
            xfer.wait_after  = (r_step[0] && i_head.long_wait) ? CLEAR_WAIT : 13'd0;
            xfer.last        = r_step[0];
        end
    end

    // output register takes a new beat when empty or being drained
    assign load  = !r_out_valid || i_out_ready;
    assign fire  = load && i_head_valid;
    assign o_pop = fire && xfer.last;

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out <= xfer;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (fire) begin
                r_out_valid <= 1'b1;
                r_step      <= xfer.last ? '0 : r_step + 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

### rtl/core/char_lcd_nibble_sequencer.sv
// Channel | Direction | Handshake                  | Beat payload
// in      | input     | i_in_valid / o_in_ready    | i_in  (t_req: opcode, byte, row, column)
// out     | output    | o_out_valid / i_out_ready  | o_out (t_xfer: RS, nibble, waits, last)
// cfg     | input     | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
//
// Beats: a byte request (command, data, cursor, clear, home) yields two beats, high
// nibble first; init yields twelve. The back end emits one nibble per cycle while a job
// is queued and the output is not stalled, stepping through each job with its counter.
// Latency: the first beat passes the queue write, then the output register load.
// Dropped requests (unknown opcode, bad row) are accepted but queue nothing.
// Reset: synchronous active-low i_rst_n empties the queue and output register and
// loads the enable timing registers with 40 and 100 units.
// Stalls: the front keeps accepting while the queue has room, even with output stalled.

module char_lcd_nibble_sequencer #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  clcd_pkg::t_req                  i_in,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output clcd_pkg::t_xfer                 o_out,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [clcd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [15:0]                     i_cfg_data
);
    import clcd_pkg::*;

    logic  push, pop, full, head_valid;
    t_job  push_job, head_job;

    // Strobe timing for the pin driver; it never shapes the beats here.
    logic [15:0] r_enable_high_units;
    logic [15:0] r_enable_low_units;

    // Config writes are always taken; unknown indexes are dropped.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable_high_units <= ENABLE_HIGH_RESET;
            r_enable_low_units  <= ENABLE_LOW_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_ENABLE_HIGH: r_enable_high_units <= i_cfg_data;
                CFG_ENABLE_LOW:  r_enable_low_units  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Front: classify each request into a byte job or an init job.
    clcd_front u_front (
        .i_req_valid (i_in_valid),
        .o_req_ready (o_in_ready),
        .i_req       (i_in),
        .i_full      (full),
        .o_push      (push),
        .o_job       (push_job)
    );

    // Queue decouples request intake from nibble emission.
    clcd_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_job),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (head_valid),
        .o_head  (head_job)
    );

    // Back: walk the head job one nibble per cycle while the output is not stalled; pop on its last beat.
    clcd_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (head_valid),
        .i_head       (head_job),
        .o_pop        (pop),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out        (o_out)
    );

`ifndef SYNTH
    // Unknown opcodes never reach the queue.
    a_drop_unknown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && (i_in.opcode > OP_HOME)) |-> !push)
        else $error("unknown opcode queued");

    // Only the first init beat carries the power-up wait.
    a_power_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.wait_before != 16'd0) |->
        (o_out.nibble == NIB_WAKE && !o_out.last && o_out.wait_after == WAKE1_WAIT))
        else $error("power-up wait on wrong beat");

    // A pop happens only with a job at the head.
    a_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> head_valid)
        else $error("pop from empty queue");

    // Enable high time changes only by a write to its index.
    a_cfg_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_cfg_valid && i_cfg_index == CFG_ENABLE_HIGH) |=> $stable(r_enable_high_units))
        else $error("enable high time changed without write");

    a_cfg_low_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_cfg_valid && i_cfg_index == CFG_ENABLE_LOW) |=> $stable(r_enable_low_units))
        else $error("enable low time changed without write");
`endif

endmodule

### verif/char_lcd_nibble_sequencer_tb.sv
module char_lcd_nibble_sequencer_tb;
    import clcd_pkg::*;

    // Run limits. The cycle limit leaves a wide margin for long stalls
    // on both channels.
    localparam int unsigned CYCLE_LIMIT     = 200000;
    localparam int unsigned QUIET_CYCLES    = 6;     // beyond the pipeline latency
    localparam int unsigned DRAIN_CYCLES    = 10;
    localparam int unsigned HOLD_CYCLES     = 400;   // long output stall
    localparam int unsigned ITEMS_PER_PHASE = 142;   // requests that give transfers

    // Opcodes the block does not know, and register indexes it must ignore
    localparam logic [2:0]           OP_SPARE_6  = 3'd6;
    localparam logic [2:0]           OP_SPARE_7  = 3'd7;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

    // Cursor rows that address a visible line
    localparam logic [1:0] ROW_TOP    = 2'd1;
    localparam logic [1:0] ROW_BOTTOM = 2'd2;

    // Tracks the nibble transfers each accepted request must produce, in order.
    class xfer_scoreboard;
        t_xfer       pending_xfers[$];
        t_xfer       burst[$];
        int unsigned failures;
        logic [15:0] strobe_high;
        logic [15:0] strobe_low;

        function new();
            failures    = 0;
            strobe_high = 16'd40;
            strobe_low  = 16'd100;
        endfunction

        // Strobe timing belongs to the pin driver; no transfer field depends on it.
        function void note_timing(logic [CFG_IDX_W-1:0] idx, logic [15:0] data);
            case (idx)
                CFG_ENABLE_HIGH: strobe_high = data;
                CFG_ENABLE_LOW:  strobe_low  = data;
                default: ;
            endcase
        endfunction

        function void add_nibble(logic rs, logic [3:0] nib, logic [15:0] wait_pre,
                                 logic [12:0] wait_post);
            t_xfer x;
            x.reg_select  = rs;
            x.nibble      = nib;
            x.wait_before = wait_pre;
            x.wait_after  = wait_post;
            x.last        = 1'b0;
            burst.push_back(x);
        endfunction

        // High nibble first; only the low nibble carries the extra wait.
        function void add_byte(logic rs, logic [7:0] b, logic [12:0] wait_post);
            add_nibble(rs, b[7:4], 16'd0, 13'd0);
            add_nibble(rs, b[3:0], 16'd0, wait_post);
        endfunction

        // Expand one accepted request; return how many transfers it gives.
        function int unsigned note_request(t_req r);
            t_xfer      tail;
            logic [7:0] cursor_pos;
            burst.delete();
            cursor_pos = {3'b000, r.column} - 8'd1;   // column 0 wraps to 0xFF
            case (r.opcode)
                OP_COMMAND: add_byte(1'b0, r.byte_value, 13'd0);
                OP_DATA:    add_byte(1'b1, r.byte_value, 13'd0);
                OP_CURSOR: begin
                    if (r.row == ROW_TOP)
                        add_byte(1'b0, ROW1_BASE | cursor_pos, 13'd0);
                    else if (r.row == ROW_BOTTOM)
                        add_byte(1'b0, ROW2_BASE | cursor_pos, 13'd0);
                end
                OP_INIT: begin
                    // Wake-up: three 0x3 nibbles, then 0x2 switches to 4-bit mode
                    add_nibble(1'b0, NIB_WAKE, 16'd40000, 13'd5000);
                    add_nibble(1'b0, NIB_WAKE, 16'd0, 13'd150);
                    add_nibble(1'b0, NIB_WAKE, 16'd0, 13'd0);
                    add_nibble(1'b0, NIB_FOUR_BIT, 16'd0, 13'd0);
                    add_byte(1'b0, CMD_FUNCTION_SET, 13'd0);
                    add_byte(1'b0, CMD_DISPLAY_ON, 13'd0);
                    add_byte(1'b0, CMD_CLEAR, 13'd2000);
                    add_byte(1'b0, CMD_ENTRY_INC, 13'd0);
                end
                OP_CLEAR: add_byte(1'b0, CMD_CLEAR, 13'd2000);
                OP_HOME:  add_byte(1'b0, CMD_HOME, 13'd2000);
                default: ;
            endcase
            if (burst.size() > 0) begin
                tail      = burst.pop_back();
                tail.last = 1'b1;
                burst.push_back(tail);
            end
            foreach (burst[i]) pending_xfers.push_back(burst[i]);
            return burst.size();
        endfunction

        function void compare_field(string name, logic [15:0] want, logic [15:0] got);
            if (got !== want) begin
                failures++;
                $display("%0t: %s mismatch, expected %0d, actual %0d",
                         $time, name, want, got);
            end
        endfunction

        function void check_xfer(t_xfer got);
            t_xfer want;
            if (pending_xfers.size() == 0) begin
                failures++;
                $display("%0t: unexpected transfer, expected none, actual %h", $time, got);
                return;
            end
            want = pending_xfers.pop_front();
            compare_field("reg_select", 16'(want.reg_select), 16'(got.reg_select));
            compare_field("nibble", 16'(want.nibble), 16'(got.nibble));
            compare_field("wait_before", want.wait_before, got.wait_before);
            compare_field("wait_after", 16'(want.wait_after), 16'(got.wait_after));
            compare_field("last", 16'(want.last), 16'(got.last));
        endfunction
    endclass

    // Block ports; every input starts at a known value
    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_in_valid  = 1'b0;
    logic                 o_in_ready;
    t_req                 i_in        = '0;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    t_xfer                o_out;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [15:0]          i_cfg_data  = '0;

    xfer_scoreboard sb = new();

    // Idle odds per cycle, in percent, set by the phase in progress
    int unsigned in_idle_pct  = 0;
    int unsigned out_idle_pct = 0;

    // Long output stall: the stimulus bumps hold_requests, the receiver
    // picks it up and counts the stall out on its own.
    int unsigned hold_requests = 0;
    int unsigned hold_taken    = 0;
    int unsigned hold_left     = 0;

    int unsigned cycle_count = 0;

    char_lcd_nibble_sequencer u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Receiver: check each accepted beat against the oldest expectation,
    // then pick ready for the next cycle. A pending hold request wins over
    // the random idling and keeps ready low for the whole stretch.
    always @(posedge i_clk) begin
        if (o_out_valid && i_out_ready)
            sb.check_xfer(o_out);
        if (hold_left == 0 && hold_taken != hold_requests) begin
            hold_taken = hold_requests;
            hold_left  = HOLD_CYCLES;
        end
        if (hold_left != 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= out_idle_pct);
        end
    end

    // Offer one request and hold it until accepted. Valid drops only when an
    // idle gap follows, so back-to-back beats keep it high without a glitch.
    task automatic send_request(input t_req r, output int unsigned produced);
        if ($urandom_range(99) < in_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < in_idle_pct);
        end
        i_in_valid <= 1'b1;
        i_in       <= r;
        do @(posedge i_clk); while (!o_in_ready);
        produced = sb.note_request(r);
    endtask

    // Drop valid, wait for every expected beat, then let dropped requests
    // still in flight work through the pipeline.
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending_xfers.size() != 0);
        repeat (QUIET_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.note_timing(idx, data);
    endtask

    // Write both timing registers and one index the block must ignore.
    task automatic program_timing(input logic [15:0] high_units, input logic [15:0] low_units,
                                  input logic [CFG_IDX_W-1:0] spare_idx);
        write_register(CFG_ENABLE_HIGH, high_units);
        write_register(CFG_ENABLE_LOW, low_units);
        write_register(spare_idx, 16'($urandom));
        i_cfg_valid <= 1'b0;
    endtask

    function automatic t_req make_req(logic [2:0] op, logic [7:0] b, logic [1:0] row,
                                      logic [4:0] col);
        t_req r;
        r.opcode     = op;
        r.byte_value = b;
        r.row        = row;
        r.column     = col;
        return r;
    endfunction

    // Mostly byte-sized requests with valid rows and columns; init is rare,
    // and a few requests carry unknown opcodes, bad rows or odd columns.
    function automatic t_req random_request();
        t_req        r;
        int unsigned pick;
        pick         = $urandom_range(99);
        r.byte_value = 8'($urandom);
        r.row        = 2'($urandom);
        r.column     = ($urandom_range(9) == 0) ? 5'($urandom) : 5'($urandom_range(16, 1));
        if (pick < 3)
            r.opcode = OP_INIT;
        else if (pick < 6)
            r.opcode = $urandom_range(1) ? OP_SPARE_6 : OP_SPARE_7;
        else if (pick < 12)
            r.opcode = OP_CLEAR;
        else if (pick < 18)
            r.opcode = OP_HOME;
        else if (pick < 50) begin
            r.opcode = OP_CURSOR;
            if ($urandom_range(4) != 0)
                r.row = $urandom_range(1) ? ROW_TOP : ROW_BOTTOM;
        end else if (pick < 75)
            r.opcode = OP_COMMAND;
        else
            r.opcode = OP_DATA;
        return r;
    endfunction

    // One random phase; dropped requests do not count toward its length.
    task automatic run_phase(input int unsigned in_pct, input int unsigned out_pct,
                             input bit with_hold);
        int unsigned counted;
        int unsigned produced;
        bit          hold_sent;
        counted      = 0;
        hold_sent    = 1'b0;
        in_idle_pct  = in_pct;
        out_idle_pct = out_pct;
        while (counted < ITEMS_PER_PHASE) begin
            // Stall the output for a long stretch while requests keep coming
            if (with_hold && !hold_sent && counted >= 40) begin
                hold_requests++;
                hold_sent = 1'b1;
            end
            send_request(random_request(), produced);
            if (produced != 0)
                counted++;
        end
    endtask

    initial begin
        int unsigned produced;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        program_timing(16'd1, 16'hFFFF, CFG_SPARE_2);

        // Directed: field extremes, every opcode, out-of-line cursor
        // positions, rows that give nothing and unknown opcodes.
        in_idle_pct  = 30;
        out_idle_pct = 48;
        send_request(make_req(OP_COMMAND, 8'h00, 2'd0, 5'd0), produced);
        send_request(make_req(OP_COMMAND, 8'hFF, 2'd3, 5'd31), produced);
        send_request(make_req(OP_DATA, 8'h00, 2'd0, 5'd0), produced);
        send_request(make_req(OP_DATA, 8'hFF, 2'd3, 5'd31), produced);
        send_request(make_req(OP_DATA, 8'h5A, 2'd1, 5'd10), produced);
        send_request(make_req(OP_CURSOR, 8'h00, ROW_TOP, 5'd1), produced);
        send_request(make_req(OP_CURSOR, 8'hFF, ROW_BOTTOM, 5'd16), produced);
        send_request(make_req(OP_CURSOR, 8'h00, ROW_TOP, 5'd0), produced);
        send_request(make_req(OP_CURSOR, 8'h00, ROW_BOTTOM, 5'd31), produced);
        send_request(make_req(OP_CURSOR, 8'h00, 2'd0, 5'd5), produced);
        send_request(make_req(OP_CURSOR, 8'h00, 2'd3, 5'd5), produced);
        send_request(make_req(OP_CURSOR, 8'h00, ROW_TOP, 5'd16), produced);
        send_request(make_req(OP_CURSOR, 8'h00, ROW_BOTTOM, 5'd1), produced);
        send_request(make_req(OP_INIT, 8'h00, 2'd0, 5'd0), produced);
        send_request(make_req(OP_CLEAR, 8'hFF, 2'd3, 5'd31), produced);
        send_request(make_req(OP_HOME, 8'h00, 2'd0, 5'd0), produced);
        send_request(make_req(OP_SPARE_6, 8'h00, ROW_TOP, 5'd1), produced);
        send_request(make_req(OP_SPARE_7, 8'hFF, 2'd3, 5'd31), produced);
        send_request(make_req(OP_COMMAND, 8'hA5, ROW_TOP, 5'd16), produced);

        // Sender idles less than the receiver; the long output stall lands here
        run_phase(30, 48, 1'b1);
        wait_idle();
        program_timing(16'hFFFF, 16'd1, CFG_SPARE_3);

        // Receiver idles less than the sender
        run_phase(48, 30, 1'b0);
        wait_idle();
        program_timing(16'($urandom_range(65535, 1)), 16'($urandom_range(65535, 1)),
                       CFG_SPARE_2);

        // Full rate on both sides
        run_phase(0, 0, 1'b0);

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.failures == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // Watchdog: a hung handshake ends the run here
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("%0t: timeout, %0d transfers still expected",
                 $time, sb.pending_xfers.size());
        $display("Verification failed");
        $finish;
    end

endmodule
